@@ hw/rtl/sfa_pkg.sv @@
// Shared types, constants and helpers of the segment-fit allocator.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;

  localparam int unsigned MaxSegmentsDefault   = 64;
  localparam int unsigned ArenaAddrBitsDefault = 20;
  localparam int unsigned SizeW   = 21;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam logic [SizeW-1:0] ArenaReset = 21'd65536;
  localparam logic [SizeW-1:0] ArenaMax   = 21'd1048576;

  typedef enum logic [1:0] {
    FitFirst = 2'd0, FitNext = 2'd1, FitBest = 2'd2, FitWorst = 2'd3
  } fit_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StNoFit = 2'd1, StFull = 2'd2, StNotFound = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CfgFitPolicy = 2'd0, CfgArenaBytes = 2'd1, CfgArenaBase = 2'd2, CfgNone = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OpAlloc = 1'b0, OpFree = 1'b1
  } op_e;

  typedef struct packed {
    logic              op;
    logic [SizeW-1:0]  request_size;
    logic [AddrW-1:0]  free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [AddrW-1:0]  granted_address;
    logic [CountW-1:0] segment_count;
  } rsp_t;

  typedef enum logic [3:0] {
    SIdle, SClear, SScanRd, SScanEv, SShiftRd, SShiftWr,
    SSplit, SMark, SFreeRd, SFreeEv, SMergeRd, SMergeWr, SPackRd, SPackWr, SDone
  } state_e;

  // One table entry as it sits in memory.
  typedef struct packed {
    logic [SizeW-1:0] offset;
    logic [SizeW-1:0] length;
    logic             in_use;
  } seg_t;

  // Round up to a multiple of four, at least four, capped at the given limit.
  function automatic logic [SizeW-1:0] eff_arena(input logic [SizeW-1:0] raw,
                                                 input logic [SizeW:0] cap);
    logic [SizeW:0] v;
    begin
      v = ({1'b0, raw} + (SizeW+1)'(3)) & ~(SizeW+1)'(3);
      if (v < (SizeW+1)'(4)) v = (SizeW+1)'(4);
      if (v > cap) v = cap;
      eff_arena = v[SizeW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sfa_seg_ram.sv @@
// Segment table memory: one write port, one registered read port.
// Depends on sfa_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module sfa_seg_ram #(
  parameter int unsigned Depth = sfa_pkg::MaxSegmentsDefault,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IdxW-1:0]  waddr_i,
  input  wire sfa_pkg::seg_t    wdata_i,
  input  wire logic [IdxW-1:0]  raddr_i,
  output sfa_pkg::seg_t         rdata_o
);
  sfa_pkg::seg_t mem [Depth];

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/segment_fit_allocator_core.sv @@
// Segment-fit allocator top level: sequencer around the segment table memory.
// Depends on sfa_pkg and sfa_seg_ram.
//
//   channel  direction  handshake            beat
//   req      in         req_valid/req_ready  sfa_pkg::req_t
//   rsp      out        rsp_valid/rsp_ready  sfa_pkg::rsp_t
//   cfg      in         cfg_we_i             index + data, no wait
//
// An allocate scans the table with a read and an evaluate per entry and, when
// it splits, shifts the entries above the pick by a read and a write each.
// A free reads and evaluates each entry up to the match, then moves entries for a merge.
// Every table access is a registered read followed by a use or a write back.
// After reset, and after a write of arena_bytes, a clearing pass writes entry 0.
// A result waits in the output register; the next beat is taken once it leaves.
`timescale 1ns / 1ps
`default_nettype none
module segment_fit_allocator_core #(
  parameter int unsigned MaxSegments   = sfa_pkg::MaxSegmentsDefault,
  parameter int unsigned ArenaAddrBits = sfa_pkg::ArenaAddrBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sfa_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sfa_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire sfa_pkg::req_t               req_i,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output sfa_pkg::rsp_t                    rsp_o
);
  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam int unsigned SW   = sfa_pkg::SizeW;
  localparam logic [SW:0] CapRaw = (ArenaAddrBits >= SW) ? (SW+1)'(1 << (SW-1))
                                   : (SW+1)'(1 << ArenaAddrBits);
  localparam logic [SW:0] ArenaCap = (CapRaw > {1'b0, sfa_pkg::ArenaMax})
                                     ? {1'b0, sfa_pkg::ArenaMax} : CapRaw;

  // Configuration registers.
  logic [1:0]                  fit_q;
  logic [SW-1:0]               arena_q;
  logic [sfa_pkg::AddrW-1:0]   base_q;
  logic                        reinit_q, reinit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q   <= sfa_pkg::FitFirst;
      arena_q <= sfa_pkg::ArenaReset;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfa_pkg::CfgFitPolicy:  fit_q   <= cfg_data_i[1:0];
        sfa_pkg::CfgArenaBytes: arena_q <= cfg_data_i[SW-1:0];
        sfa_pkg::CfgArenaBase:  base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign reinit_d = cfg_we_i && (cfg_idx_i == sfa_pkg::CfgArenaBytes);

  // Memory ports.
  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  sfa_pkg::seg_t    wdata, rdata;

  sfa_seg_ram #(.Depth(MaxSegments)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Sequencer state.
  sfa_pkg::state_e  st_q, st_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [IdxW-1:0]  i_q, i_d;
  logic [IdxW-1:0]  k_q, k_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  pick_q, pick_d;
  logic             found_q, found_d;
  logic [SW-1:0]    best_q, best_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic             curv_q, curv_d;
  logic             op_q, op_d;
  logic [SW-1:0]    size_q, size_d;
  logic [SW-1:0]    foff_q, foff_d;
  logic             foff_ok_q, foff_ok_d;
  sfa_pkg::seg_t    ent_q, ent_d;
  sfa_pkg::seg_t    carry_q, carry_d;
  logic             rv_q, rv_d;
  sfa_pkg::rsp_t    rsp_q, rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= sfa_pkg::SClear;
      total_q  <= CntW'(1);
      curv_q   <= 1'b0;
      rv_q     <= 1'b0;
      reinit_q <= 1'b0;
    end else begin
      st_q     <= reinit_d ? sfa_pkg::SClear : st_d;
      total_q  <= total_d;
      curv_q   <= curv_d;
      rv_q     <= rv_d;
      reinit_q <= reinit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; k_q <= k_d; cnt_q <= cnt_d; pick_q <= pick_d;
    found_q <= found_d; best_q <= best_d; cur_q <= cur_d; op_q <= op_d;
    size_q <= size_d; foff_q <= foff_d; foff_ok_q <= foff_ok_d;
    ent_q <= ent_d; carry_q <= carry_d; rsp_q <= rsp_d;
  end

  assign req_ready = (st_q == sfa_pkg::SIdle) && !rv_q && !reinit_q;
  assign rsp_valid = rv_q;
  assign rsp_o     = rsp_q;

  logic [SW:0]      req_round;
  logic [sfa_pkg::AddrW-1:0] fdiff;
  logic [SW-1:0]    left;
  logic             fits;
  logic [IdxW:0]    idx_wrap;

  assign req_round = ({1'b0, req_i.request_size} + (SW+1)'(3)) & ~(SW+1)'(3);
  assign fdiff     = req_i.free_address - base_q;
  assign left      = rdata.length - size_q;
  assign fits      = !rdata.in_use && (rdata.length >= size_q);

  // Next state and datapath of the sequencer.
  always_comb begin
    st_d = st_q; total_d = total_q; i_d = i_q; k_d = k_q; cnt_d = cnt_q;
    pick_d = pick_q; found_d = found_q; best_d = best_q; cur_d = cur_q;
    curv_d = curv_q; op_d = op_q; size_d = size_q; foff_d = foff_q;
    foff_ok_d = foff_ok_q; ent_d = ent_q; carry_d = carry_q;
    rv_d = rv_q; rsp_d = rsp_q;
    we = 1'b0; waddr = i_q; wdata = ent_q; raddr = i_q;
    idx_wrap = '0;
    if (rv_q && rsp_ready) rv_d = 1'b0;
    unique case (st_q)
      sfa_pkg::SClear: begin
        we = 1'b1; waddr = '0;
        wdata = '{offset: '0, length: sfa_pkg::eff_arena(arena_q, ArenaCap), in_use: 1'b0};
        total_d = CntW'(1); curv_d = 1'b0;
        st_d = sfa_pkg::SIdle;
      end
      sfa_pkg::SIdle: begin
        if (req_valid && req_ready) begin
          op_d = req_i.op;
          size_d = req_round[SW-1:0];
          foff_d = fdiff[SW-1:0];
          foff_ok_d = (fdiff >> SW) == '0;
          found_d = 1'b0; best_d = '0; pick_d = '0; cnt_d = '0;
          if (req_i.op == sfa_pkg::OpAlloc) begin
            k_d = (fit_q == sfa_pkg::FitNext && curv_q &&
                   {1'b0, cur_q} < (IdxW+1)'(total_q)) ? cur_q : '0;
            i_d = k_d;
            st_d = (req_round[SW:0] == '0 || req_round[SW]) ?
                   sfa_pkg::SDone : sfa_pkg::SScanRd;
          end else begin
            i_d = '0;
            st_d = sfa_pkg::SFreeRd;
          end
        end
      end
      sfa_pkg::SScanRd: begin
        raddr = i_q; st_d = sfa_pkg::SScanEv;
      end
      sfa_pkg::SScanEv: begin
        if (fits && (!found_q ||
            (fit_q == sfa_pkg::FitBest && left < best_q) ||
            (fit_q == sfa_pkg::FitWorst && left > best_q))) begin
          found_d = 1'b1; pick_d = i_q; best_d = left; ent_d = rdata;
        end
        cnt_d = cnt_q + CntW'(1);
        idx_wrap = {1'b0, i_q} + (IdxW+1)'(1);
        if (idx_wrap >= (IdxW+1)'(total_q)) idx_wrap = '0;
        i_d = idx_wrap[IdxW-1:0];
        if ((fits && (fit_q == sfa_pkg::FitFirst || fit_q == sfa_pkg::FitNext)) ||
            cnt_d == total_q) begin
          if (!found_d) begin
            st_d = sfa_pkg::SDone;
          end else if (ent_d.length > size_q) begin
            if (total_q >= CntW'(MaxSegments)) begin
              found_d = 1'b0; rsp_d.status = sfa_pkg::StFull;
              st_d = sfa_pkg::SDone;
            end else begin
              // Shift entries pick+1..total-1 up by one, from the top.
              i_d = IdxW'(total_q - CntW'(1));
              st_d = ({1'b0, pick_d} + (IdxW+1)'(1) >= (IdxW+1)'(total_q)) ?
                     sfa_pkg::SSplit : sfa_pkg::SShiftRd;
            end
          end else begin
            st_d = sfa_pkg::SMark;
          end
        end else begin
          st_d = sfa_pkg::SScanRd;
        end
      end
      sfa_pkg::SShiftRd: begin
        raddr = i_q; st_d = sfa_pkg::SShiftWr;
      end
      sfa_pkg::SShiftWr: begin
        we = 1'b1; waddr = i_q + IdxW'(1); wdata = rdata;
        i_d = i_q - IdxW'(1);
        st_d = (i_q == pick_q + IdxW'(1)) ? sfa_pkg::SSplit : sfa_pkg::SShiftRd;
      end
      sfa_pkg::SSplit: begin
        we = 1'b1; waddr = pick_q + IdxW'(1);
        wdata = '{offset: ent_q.offset + size_q, length: ent_q.length - size_q,
                  in_use: 1'b0};
        total_d = total_q + CntW'(1);
        if (curv_q && cur_q > pick_q) cur_d = cur_q + IdxW'(1);
        ent_d.length = size_q;
        st_d = sfa_pkg::SMark;
      end
      sfa_pkg::SMark: begin
        we = 1'b1; waddr = pick_q;
        wdata = '{offset: ent_q.offset, length: ent_q.length, in_use: 1'b1};
        if (fit_q == sfa_pkg::FitNext) begin
          cur_d = pick_q; curv_d = 1'b1;
        end
        st_d = sfa_pkg::SDone;
      end
      sfa_pkg::SFreeRd: begin
        raddr = i_q; st_d = sfa_pkg::SFreeEv;
      end
      sfa_pkg::SFreeEv: begin
        if (foff_ok_q && rdata.offset == foff_q) begin
          found_d = 1'b1; pick_d = i_q;
          ent_d = '{offset: rdata.offset, length: rdata.length, in_use: 1'b0};
          st_d = ({1'b0, i_q} + (IdxW+1)'(1) < (IdxW+1)'(total_q)) ?
                 sfa_pkg::SMergeRd : sfa_pkg::SMergeWr;
          i_d = i_q + IdxW'(1);
        end else if ({1'b0, i_q} + (IdxW+1)'(1) >= (IdxW+1)'(total_q)) begin
          st_d = sfa_pkg::SDone;
        end else begin
          i_d = i_q + IdxW'(1); st_d = sfa_pkg::SFreeRd;
        end
      end
      sfa_pkg::SMergeRd: begin
        raddr = i_q; st_d = sfa_pkg::SMergeWr;
      end
      sfa_pkg::SMergeWr: begin
        // Write the freed entry, absorbing a following hole if one was read.
        we = 1'b1; waddr = pick_q; wdata = ent_q;
        st_d = sfa_pkg::SDone;
        if ({1'b0, pick_q} + (IdxW+1)'(1) < (IdxW+1)'(total_q) && !rdata.in_use) begin
          wdata.length = ent_q.length + rdata.length;
          total_d = total_q - CntW'(1);
          if (curv_q) begin
            if (cur_q == pick_q + IdxW'(1)) cur_d = pick_q;
            else if (cur_q > pick_q + IdxW'(1)) cur_d = cur_q - IdxW'(1);
          end
          i_d = pick_q + IdxW'(2);
          k_d = pick_q + IdxW'(1);
          if ({1'b0, pick_q} + (IdxW+1)'(2) < (IdxW+1)'(total_q)) st_d = sfa_pkg::SPackRd;
        end
      end
      sfa_pkg::SPackRd: begin
        raddr = i_q; st_d = sfa_pkg::SPackWr;
      end
      sfa_pkg::SPackWr: begin
        we = 1'b1; waddr = k_q; wdata = rdata;
        k_d = i_q; i_d = i_q + IdxW'(1);
        st_d = ({1'b0, i_q} + (IdxW+1)'(1) < (IdxW+1)'(total_q) + (IdxW+1)'(1)) ?
               sfa_pkg::SPackRd : sfa_pkg::SDone;
      end
      sfa_pkg::SDone: begin
        rv_d = 1'b1;
        rsp_d.segment_count = sfa_pkg::CountW'(total_q);
        rsp_d.granted_address = '0;
        if (op_q == sfa_pkg::OpFree) begin
          rsp_d.status = found_q ? sfa_pkg::StOk : sfa_pkg::StNotFound;
        end else if (found_q) begin
          rsp_d.status = sfa_pkg::StOk;
          rsp_d.granted_address = base_q + sfa_pkg::AddrW'(ent_q.offset);
        end else if (rsp_q.status != sfa_pkg::StFull || st_q != sfa_pkg::SDone) begin
          rsp_d.status = sfa_pkg::StNoFit;
        end
        if (!found_q && rsp_q.status == sfa_pkg::StFull) rsp_d.status = sfa_pkg::StFull;
        st_d = sfa_pkg::SIdle;
      end
      default: st_d = sfa_pkg::SIdle;
    endcase
    // Clear a stale full status at the start of every item.
    if (st_q == sfa_pkg::SIdle && req_valid && req_ready) rsp_d.status = sfa_pkg::StOk;
  end
endmodule
`default_nettype wire

@@ hw/rtl/sfa_checker.sv @@
// Port-level checker for the segment-fit allocator, bound to the top level.
// Depends on sfa_pkg and segment_fit_allocator_core.
`timescale 1ns / 1ps
`default_nettype none
module sfa_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire sfa_pkg::rsp_t rsp_o
);
  // No new beat is taken while a result waits.
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("beat taken while result pending");

  // A failed allocate or a failed free reports address zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_o.status != sfa_pkg::StOk |-> rsp_o.granted_address == '0)
    else $error("nonzero address on failure");

  // The table never becomes empty.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_o.segment_count != '0) else $error("empty table");

  // A result stays until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_o))
    else $error("result dropped");
endmodule

bind segment_fit_allocator_core sfa_checker u_sfa_checker (
  .clk_i, .rst_ni, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_o
);
`default_nettype wire
